### rtl/lasm_pkg.sv
// package: item types, link type between cells, register indexes and reset values
`default_nettype none

package lasm_pkg;

    // pattern and row geometry
    localparam int PATTERN_LENGTH = 16;
    localparam int SCORE_W        = 5;
    localparam int CFG_INDEX_W    = 3;
    localparam int PATTERN_WORDS  = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD3 = 3'd4;

    // register reset values ("sponsored-search", threshold 4)
    localparam logic [SCORE_W-1:0] THRESHOLD_RESET     = 5'd4;
    localparam logic [31:0]        PATTERN_WORD0_RESET = 32'd1852797043;
    localparam logic [31:0]        PATTERN_WORD1_RESET = 32'd1701998451;
    localparam logic [31:0]        PATTERN_WORD2_RESET = 32'd1702047076;
    localparam logic [31:0]        PATTERN_WORD3_RESET = 32'd1751347809;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] hit_count;
    } out_item_t;

    // what one cell hands to the next
    typedef struct packed {
        logic               valid;
        logic [7:0]         text_byte;
        logic               last_byte;
        logic [SCORE_W-1:0] running;
        logic               hit;
    } lasm_link_t;

endpackage

`default_nettype wire

### rtl/lasm_cell.sv
// one pattern position of the alignment row: holds its score, passes the byte on
`default_nettype none

module lasm_cell
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [7:0]                 pattern_byte,
    input  wire logic [lasm_pkg::SCORE_W-1:0] threshold,
    input  wire lasm_pkg::lasm_link_t       link_in,
    output lasm_pkg::lasm_link_t            link_out
);
    import lasm_pkg::*;

    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    lasm_link_t         link_reg;
    lasm_link_t         link_next;

    logic signed [SCORE_W+1:0] run_s;
    logic signed [SCORE_W+1:0] old_s;
    logic signed [SCORE_W+1:0] diag_s;
    logic signed [SCORE_W+1:0] gap_s;
    logic signed [SCORE_W+1:0] best_s;
    logic signed [SCORE_W+1:0] run_dec_s;
    logic [SCORE_W-1:0]        best;
    logic [SCORE_W-1:0]        running_next;

    // score update for this position
    always_comb
    begin
        run_s     = $signed({2'b00, link_in.running});
        old_s     = $signed({2'b00, score_reg});
        diag_s    = (link_in.text_byte == pattern_byte) ? run_s + 7'sd1 : run_s - 7'sd1;
        gap_s     = old_s - 7'sd1;
        best_s    = (diag_s > gap_s) ? diag_s : gap_s;
        if (best_s < 7'sd0)
        begin
            best_s = 7'sd0;
        end
        best      = best_s[SCORE_W-1:0];
        run_dec_s = run_s - 7'sd1;
        running_next = (run_dec_s > old_s) ? run_dec_s[SCORE_W-1:0] : score_reg;
    end

    // next state: the row clears behind the last byte
    always_comb
    begin
        score_next          = score_reg;
        link_next           = link_reg;
        link_next.valid     = link_in.valid;
        if (link_in.valid)
        begin
            score_next          = link_in.last_byte ? '0 : best;
            link_next.text_byte = link_in.text_byte;
            link_next.last_byte = link_in.last_byte;
            link_next.running   = running_next;
            link_next.hit       = link_in.hit || (best >= threshold);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            link_reg  <= '0;
        end
        else if (advance)
        begin
            score_reg <= score_next;
            link_reg  <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

### rtl/lasm_tail.sv
// end of the row: position and hit counters, output register
`default_nettype none

module lasm_tail
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire lasm_pkg::lasm_link_t link_in,
    output logic                      out_valid,
    output lasm_pkg::out_item_t       out_data
);
    import lasm_pkg::*;

    logic [31:0] pos_reg;
    logic [31:0] pos_next;
    logic [31:0] hits_reg;
    logic [31:0] hits_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;
    logic [31:0] hits_inc;

    // counters and result load
    always_comb
    begin
        hits_inc       = hits_reg + 32'd1;
        pos_next       = pos_reg;
        hits_next      = hits_reg;
        out_valid_next = 1'b0;
        out_data_next  = out_data_reg;
        if (link_in.valid)
        begin
            pos_next = pos_reg + 32'd1;
            if (link_in.hit)
            begin
                hits_next              = hits_inc;
                out_valid_next         = 1'b1;
                out_data_next.position = pos_reg;
                out_data_next.hit_count = hits_inc;
            end
            if (link_in.last_byte)
            begin
                pos_next  = '0;
                hits_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg       <= pos_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/local_alignment_stream_matcher.sv
// top level: configuration registers, row of alignment cells, counter tail
// path: an accepted byte loads the first of the 16 cell registers, then passes the other
// cells in order, and the tail register then offers any result
// throughput: one byte per cycle while no result is held; each cell holds one score and
// passes the byte on whenever the row advances, so a byte reaches cell j after cell j-1
// the whole row freezes while a result waits under out_stall
// reset: scores and counters clear, threshold 4, pattern "sponsored-search"
`default_nettype none

module local_alignment_stream_matcher
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire lasm_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output lasm_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lasm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                       cfg_data
);
    import lasm_pkg::*;

    logic [SCORE_W-1:0]                  threshold_reg;
    logic [PATTERN_WORDS-1:0][31:0]      pattern_reg;
    logic [PATTERN_WORDS*32-1:0]         pattern_flat;
    lasm_link_t                          links [PATTERN_LENGTH+1];
    logic                                advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            pattern_reg[0] <= PATTERN_WORD0_RESET;
            pattern_reg[1] <= PATTERN_WORD1_RESET;
            pattern_reg[2] <= PATTERN_WORD2_RESET;
            pattern_reg[3] <= PATTERN_WORD3_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD:     threshold_reg  <= cfg_data[SCORE_W-1:0];
                CFG_PATTERN_WORD0: pattern_reg[0] <= cfg_data;
                CFG_PATTERN_WORD1: pattern_reg[1] <= cfg_data;
                CFG_PATTERN_WORD2: pattern_reg[2] <= cfg_data;
                CFG_PATTERN_WORD3: pattern_reg[3] <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign pattern_flat = pattern_reg;

    // the row moves unless a result is held
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // entry into the first cell: valid, byte, last flag, zero running value, no hit
    assign links[0] = {in_valid, in_data.text_byte, in_data.last_byte,
                       {SCORE_W{1'b0}}, 1'b0};

    // row of cells
    for (genvar j = 0; j < PATTERN_LENGTH; j++)
    begin : g_cell
        lasm_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .pattern_byte (pattern_flat[j*8 +: 8]),
            .threshold    (threshold_reg),
            .link_in      (links[j]),
            .link_out     (links[j+1])
        );
    end

    // counters and result register
    lasm_tail u_tail
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .link_in   (links[PATTERN_LENGTH]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### rtl/lasm_checker.sv
// port checker for the matcher and its bind
`default_nettype none

module lasm_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire lasm_pkg::out_item_t               out_data,
    input  wire logic                              cfg_ready
);
    import lasm_pkg::*;

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // a held result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed under stall");

    // input stalls exactly when a result is held
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow held result");

    // configuration port always takes a write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind local_alignment_stream_matcher lasm_checker u_lasm_checker (.*);

`default_nettype wire
